// ===== rtl/callsign_hash_cache_defines.svh =====
// assertion macros shared by the callsign hash cache rtl
`ifndef CALLSIGN_HASH_CACHE_DEFINES_SVH
`define CALLSIGN_HASH_CACHE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chc_pkg.sv =====
// types, codes and helpers of the callsign hash cache
package chc_pkg;

  localparam int HASH_W     = 22;
  localparam int HEAD_W     = 64;
  localparam int TAIL_W     = 24;
  localparam int BUCKET_W   = 10;
  localparam int BUCKET_SH  = 12;
  localparam int DIVIDEND_W = 15;
  localparam int STRIDE     = 23;
  localparam int COUNT_W    = 9;

  // commands
  localparam logic CMD_SAVE   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // lookup widths
  localparam logic [1:0] KIND_TEN    = 2'd0;
  localparam logic [1:0] KIND_TWELVE = 2'd1;

  // save status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] CH_LT = 8'h3C;

  // one table entry as held in the store
  typedef struct packed {
    logic              occ;
    logic [HASH_W-1:0] key;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
  } chc_entry_t;

  // zero every byte that follows the first zero byte of the 11-byte name
  function automatic logic [HEAD_W+TAIL_W-1:0] trim_name(input logic [HEAD_W+TAIL_W-1:0] name);
    logic [HEAD_W+TAIL_W-1:0] res;
    logic                     ended;
    res   = name;
    ended = 1'b0;
    for (int i = 0; i < 11; i++) begin
      if (ended) begin
        res[HEAD_W+TAIL_W-1-8*i -: 8] = 8'h00;
      end else if (name[HEAD_W+TAIL_W-1-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/chc_if.sv =====
// request and result channel interfaces of the callsign hash cache
interface chc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [63:0]          name_head;
  logic [23:0]          name_tail;
  logic [21:0]          hash_value;
  logic [1:0]           hash_kind;

  modport source (output valid, command, name_head, name_tail, hash_value, hash_kind,
                  input ready);
  modport sink   (input valid, command, name_head, name_tail, hash_value, hash_kind,
                  output ready);
endinterface

interface chc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] found_head;
  logic [23:0] found_tail;
  logic [1:0]  save_status;
  logic [8:0]  entry_count;

  modport source (output valid, found, found_head, found_tail, save_status, entry_count,
                  input ready);
  modport sink   (input valid, found, found_head, found_tail, save_status, entry_count,
                  output ready);
endinterface

// ===== rtl/chc_store.sv =====
// entry memory: one write port, one read port with registered data
module chc_store #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  chc_pkg::chc_entry_t        wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output chc_pkg::chc_entry_t        rdata
);
  import chc_pkg::*;

  chc_entry_t mem [ENTRIES];
  chc_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/chc_bucket_mod.sv =====
// remainder of the probe start by the table size, by reciprocal multiplication
module chc_bucket_mod #(
  parameter int ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [chc_pkg::DIVIDEND_W-1:0]      dividend,
  output logic                                done,
  output logic [$clog2(ENTRIES)-1:0]          rem
);
  import chc_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int PW  = 2 * DIVIDEND_W + 1;
  localparam int RSH = DIVIDEND_W + IW;
  // ceiling of 2^RSH over the table size, exact quotient for any 15-bit dividend
  localparam longint RECIP_L =
    ((longint'(1) << RSH) + longint'(ENTRIES) - longint'(1)) / longint'(ENTRIES);
  localparam logic [DIVIDEND_W:0]   RECIP   = (DIVIDEND_W+1)'(RECIP_L);
  localparam logic [DIVIDEND_W-1:0] DIVISOR = DIVIDEND_W'(ENTRIES);

  logic [PW-1:0]         prod;
  logic [DIVIDEND_W-1:0] quot_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic                  stage_r;
  logic                  done_r;
  logic [IW-1:0]         rem_r;

  // quotient by multiplying with the reciprocal
  assign prod = PW'(dividend) * PW'(RECIP);

  // two-step pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  // first step keeps the quotient, second step forms the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= DIVIDEND_W'(prod >> RSH);
      dvd_r  <= dividend;
    end
    if (stage_r) begin
      rem_r <= IW'(dvd_r - quot_r * DIVISOR);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/callsign_hash_cache.sv =====
// top level of the callsign hash cache: control sequencer and result register
//
// Maps 22-bit callsign hashes to names of up to 11 bytes, in a table of
// TABLE_ENTRIES entries held in one synchronous memory.
// in_if carries requests (valid/ready): a save with name and full hash, or a
// lookup with a query hash and its width kind. out_if returns one result per
// request, in order.
// One request is worked on at a time. A save first forms its start bucket,
// then probes one entry per cycle through the memory read port; a lookup
// scans from entry 0 the same way.
// A lookup that misses visits all TABLE_ENTRIES entries, a save probes at
// most TABLE_ENTRIES, and a save with an empty name or one starting with '<'
// probes none.
// in_if.ready comes back in the cycle after the result is loaded.
// After reset the block clears the memory, one entry a cycle, with in_if.ready
// low until the clearing pass ends.
// The result register lets the next request be taken while a result waits;
// if the receiver stalls, the following result holds in the sequencer until
// the register frees.
module callsign_hash_cache #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic clk,
  input  logic rst_n,
  chc_in_if.sink    in_if,
  chc_out_if.source out_if
);
  import chc_pkg::*;
  `include "callsign_hash_cache_defines.svh"

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW:0]   N_CNT    = (IW+1)'(TABLE_ENTRIES);
  localparam logic [IW:0]   LAST_CNT = (IW+1)'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_r;
  logic              cmd_r;
  logic [HEAD_W-1:0] head_r;
  logic [TAIL_W-1:0] tail_r;
  logic [HASH_W-1:0] key_r;
  logic [1:0]        kind_r;
  logic [IW-1:0]     clr_idx_r;
  logic [IW-1:0]     issue_idx_r;
  logic [IW:0]       issue_cnt_r;
  logic [IW-1:0]     eval_idx_r;
  logic [IW:0]       eval_cnt_r;
  logic              rvalid_r;
  logic [CW-1:0]     count_r;

  logic              res_found_r;
  logic [HEAD_W-1:0] res_head_r;
  logic [TAIL_W-1:0] res_tail_r;
  logic [1:0]        res_status_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [HEAD_W-1:0] out_head_r;
  logic [TAIL_W-1:0] out_tail_r;
  logic [1:0]        out_status_r;
  logic [8:0]        out_count_r;

  logic                      in_acc;
  logic                      ignored;
  logic [HEAD_W+TAIL_W-1:0]  trimmed;
  logic [DIVIDEND_W-1:0]     dividend;
  logic                      div_start;
  logic                      div_done;
  logic [IW-1:0]             div_rem;

  chc_entry_t        ent;
  chc_entry_t        mem_wdata;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [HASH_W-1:0] shifted;
  logic              lk_hit;
  logic              save_free;
  logic              save_dup;
  logic              last_eval;
  logic              evaluating;
  logic              decide;
  logic              issue;
  logic              out_free;
  logic              loading;
  logic [CW+8:0]     count_ext;

  // request side
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ignored     = (in_if.name_head[63:56] == 8'h00) || (in_if.name_head[63:56] == CH_LT);
  assign trimmed     = trim_name({in_if.name_head, in_if.name_tail});
  assign div_start   = in_acc && (in_if.command == CMD_SAVE) && !ignored;
  assign dividend    = DIVIDEND_W'(in_if.hash_value[BUCKET_SH +: BUCKET_W])
                       * DIVIDEND_W'(STRIDE);

  chc_bucket_mod #(.ENTRIES(TABLE_ENTRIES)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .done     (div_done),
    .rem      (div_rem)
  );

  chc_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (issue_idx_r),
    .rdata (ent)
  );

  // evaluate the entry read in the previous cycle
  always_comb begin
    unique case (kind_r)
      KIND_TEN:    shifted = ent.key >> 12;
      KIND_TWELVE: shifted = ent.key >> 10;
      default:     shifted = ent.key;
    endcase
  end

  assign lk_hit     = ent.occ && (shifted == key_r);
  assign save_free  = !ent.occ;
  assign save_dup   = ent.occ && (ent.key == key_r);
  assign last_eval  = (eval_cnt_r == LAST_CNT);
  assign evaluating = (state_r == S_SCAN) && rvalid_r;
  assign decide     = evaluating && ((cmd_r == CMD_SAVE) ? (save_free || save_dup || last_eval)
                                                         : (lk_hit || last_eval));
  assign issue      = (state_r == S_SCAN) && (issue_cnt_r != N_CNT) && !decide;

  // memory write: clearing pass or insert
  assign mem_we    = (state_r == S_CLEAR) ||
                     (decide && (cmd_r == CMD_SAVE) && save_free);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_idx_r : eval_idx_r;
  always_comb begin
    mem_wdata = '0;
    if (state_r != S_CLEAR) begin
      mem_wdata.occ  = 1'b1;
      mem_wdata.key  = key_r;
      mem_wdata.head = head_r;
      mem_wdata.tail = tail_r;
    end
  end

  // result register handoff
  assign out_free = !out_valid_r || out_if.ready;
  assign loading  = (state_r == S_FIN) && out_free;

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      issue_cnt_r <= '0;
      eval_cnt_r  <= '0;
      rvalid_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rvalid_r <= issue;
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (evaluating) begin
        eval_cnt_r <= eval_cnt_r + 1'b1;
      end
      if (mem_we && (state_r == S_SCAN)) begin
        count_r <= count_r + 1'b1;
      end
      if (loading) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            issue_cnt_r <= '0;
            eval_cnt_r  <= '0;
            if (in_if.command == CMD_LOOKUP) begin
              state_r <= S_SCAN;
            end else if (ignored) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (decide) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // request latch, probe addresses and pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= in_if.command;
      head_r       <= trimmed[HEAD_W+TAIL_W-1:TAIL_W];
      tail_r       <= trimmed[TAIL_W-1:0];
      key_r        <= in_if.hash_value;
      kind_r       <= in_if.hash_kind;
      issue_idx_r  <= '0;
      res_found_r  <= 1'b0;
      res_head_r   <= '0;
      res_tail_r   <= '0;
      res_status_r <= (in_if.command == CMD_SAVE && ignored) ? ST_IGNORED : ST_INSERTED;
    end else if (div_done && state_r == S_DIV) begin
      issue_idx_r <= div_rem;
    end else if (issue) begin
      eval_idx_r  <= issue_idx_r;
      issue_idx_r <= (issue_idx_r == LAST_IDX) ? '0 : issue_idx_r + 1'b1;
    end
    if (decide) begin
      if (cmd_r == CMD_SAVE) begin
        res_status_r <= save_free ? ST_INSERTED : (save_dup ? ST_PRESENT : ST_FULL);
      end else if (lk_hit) begin
        res_found_r <= 1'b1;
        res_head_r  <= ent.head;
        res_tail_r  <= ent.tail;
      end
    end
  end

  // result register payload
  assign count_ext = {9'd0, count_r};
  always_ff @(posedge clk) begin
    if (loading) begin
      out_found_r  <= res_found_r;
      out_head_r   <= res_head_r;
      out_tail_r   <= res_tail_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_ext[8:0];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.found       = out_found_r;
  assign out_if.found_head  = out_head_r;
  assign out_if.found_tail  = out_tail_r;
  assign out_if.save_status = out_status_r;
  assign out_if.entry_count = out_count_r;

  // checks
  `CHC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(TABLE_ENTRIES), "entry count beyond table size")
  `CHC_ASSERT_NEXT(a_insert_counts, clk, rst_n, mem_we && state_r == S_SCAN, count_r == CW'($past(count_r) + 1'b1), "insert not counted")
  `CHC_ASSERT_NEXT(a_read_in_scan, clk, rst_n, issue, state_r == S_SCAN && rvalid_r, "read data lost outside scan")
  `CHC_ASSERT_IMPL(a_div_in_div, clk, rst_n, div_done, state_r == S_DIV, "bucket remainder outside its step")

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the callsign hash cache: directed and random save and lookup requests
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import chc_pkg::*;

  localparam int ENTRIES        = 256;
  localparam int TWELVE_SH      = 10;
  localparam int RANDOM_ITEMS   = 830;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 2000;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 12000;

  // lookup widths that the package leaves unnamed
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic              command;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic [HASH_W-1:0] hash;
    logic [1:0]        kind;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } reply_t;

  // mirror of the table plus the replies still owed by the block
  class chc_scoreboard;
    bit              occ     [ENTRIES];
    bit [HASH_W-1:0] key_at  [ENTRIES];
    bit [HEAD_W-1:0] head_at [ENTRIES];
    bit [TAIL_W-1:0] tail_at [ENTRIES];
    int unsigned     filled;
    reply_t          awaited[$];
    int              errors;

    function reply_t predict_reply(request_t r);
      reply_t                   rep;
      int unsigned              slot;
      int                       shift;
      logic [HEAD_W+TAIL_W-1:0] name;
      logic [HEAD_W+TAIL_W-1:0] mask;
      rep = '0;
      if (r.command == CMD_SAVE) begin
        if (r.head[HEAD_W-1 -: 8] == 8'h00 || r.head[HEAD_W-1 -: 8] == CH_LT) begin
          rep.status = ST_IGNORED;
        end else begin
          // linear probe from the bucket's home slot
          slot = (int'(r.hash[HASH_W-1 -: BUCKET_W]) * STRIDE) % ENTRIES;
          rep.status = ST_FULL;
          for (int n = 0; n < ENTRIES; n++) begin
            if (!occ[slot]) begin
              // keep bytes up to the first terminator only
              name = {r.head, r.tail};
              for (int b = 0; b < 11; b++) begin
                if (name[87-8*b -: 8] == 8'h00) begin
                  mask = ~((88'(1) << (80 - 8*b)) - 88'(1));
                  name = name & mask;
                  break;
                end
              end
              occ[slot]     = 1'b1;
              key_at[slot]  = r.hash;
              head_at[slot] = name[87:24];
              tail_at[slot] = name[23:0];
              filled++;
              rep.status = ST_INSERTED;
              break;
            end
            if (key_at[slot] == r.hash) begin
              rep.status = ST_PRESENT;
              break;
            end
            slot = (slot + 1) % ENTRIES;
          end
        end
      end else begin
        // first occupied entry in index order whose shifted key matches
        shift = (r.kind == KIND_TEN) ? BUCKET_SH : (r.kind == KIND_TWELVE) ? TWELVE_SH : 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (occ[i] && (key_at[i] >> shift) == r.hash) begin
            rep.found = 1'b1;
            rep.head  = head_at[i];
            rep.tail  = tail_at[i];
            break;
          end
        end
      end
      rep.count = COUNT_W'(filled);
      return rep;
    endfunction

    function void note_request(request_t r);
      awaited.push_back(predict_reply(r));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, got %0h",
                 $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("found_head", want.head, got.head);
      compare_field("found_tail", want.tail, got.tail);
      compare_field("save_status", want.status, got.status);
      compare_field("entry_count", want.count, got.count);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  chc_in_if  in_bus();
  chc_out_if out_bus();

  callsign_hash_cache #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  chc_scoreboard     board;
  logic [HASH_W-1:0] seen_keys[$];
  bit                send_burst;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // name string packed with byte 0 on top, zero padded
  function automatic logic [87:0] pack_name(input string s);
    logic [87:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 11; i++) begin
      v[87-8*i -: 8] = s[i];
    end
    return v;
  endfunction

  function automatic request_t save_req(input logic [87:0] name, input logic [HASH_W-1:0] hash);
    request_t r;
    r.command = CMD_SAVE;
    r.head    = name[87:24];
    r.tail    = name[23:0];
    r.hash    = hash;
    r.kind    = KIND_TEN;
    return r;
  endfunction

  function automatic request_t lookup_req(input logic [HASH_W-1:0] hash, input logic [1:0] kind);
    request_t r;
    r.command = CMD_LOOKUP;
    r.head    = {$urandom, $urandom};
    r.tail    = TAIL_W'($urandom);
    r.hash    = hash;
    r.kind    = kind;
    return r;
  endfunction

  // callsign-like name, sometimes with junk after the terminator
  function automatic logic [87:0] random_callsign();
    logic [87:0] name;
    int          len;
    bit          junk;
    string       alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/";
    name     = '0;
    len      = $urandom_range(1, 11);
    junk     = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 11; i++) begin
      if (i < len) begin
        name[87-8*i -: 8] = alphabet[$urandom_range(0, alphabet.len() - 1)];
      end else if (i > len && junk) begin
        name[87-8*i -: 8] = 8'($urandom);
      end
    end
    return name;
  endfunction

  // random request: save-heavy early to fill the table, mixed later
  function automatic request_t make_request(input int step);
    request_t          r;
    logic [87:0]       name;
    logic [HASH_W-1:0] base;
    int                pick;
    int                save_pct;
    save_pct = (step < 450) ? 85 : 45;
    r.kind   = 2'($urandom);
    r.head   = {$urandom, $urandom};
    r.tail   = TAIL_W'($urandom);
    base     = (seen_keys.size() != 0) ? seen_keys[$urandom_range(0, seen_keys.size() - 1)]
                                       : HASH_W'($urandom);
    if ($urandom_range(0, 99) < save_pct) begin
      r.command = CMD_SAVE;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        r.head[HEAD_W-1 -: 8] = 8'h00;
      end else if (pick == 1) begin
        r.head[HEAD_W-1 -: 8] = CH_LT;
      end else if (pick > 3) begin
        name   = random_callsign();
        r.head = name[87:24];
        r.tail = name[23:0];
      end
      pick = $urandom_range(0, 7);
      if (seen_keys.size() != 0 && pick < 2) begin
        r.hash = base;
      end else if (seen_keys.size() != 0 && pick < 4) begin
        r.hash = {base[HASH_W-1 -: BUCKET_W], 12'($urandom)};
      end else begin
        r.hash = HASH_W'($urandom);
      end
      seen_keys.push_back(r.hash);
    end else begin
      r.command = CMD_LOOKUP;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        case (r.kind)
          KIND_TEN:    r.hash = base >> BUCKET_SH;
          KIND_TWELVE: r.hash = base >> TWELVE_SH;
          default:     r.hash = base;
        endcase
      end else if (pick < 8) begin
        r.hash = HASH_W'($urandom_range(0, 4095));
      end else begin
        r.hash = HASH_W'($urandom);
      end
    end
    return r;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(input request_t r);
    in_bus.valid      <= 1'b1;
    in_bus.command    <= r.command;
    in_bus.name_head  <= r.head;
    in_bus.name_tail  <= r.tail;
    in_bus.hash_value <= r.hash;
    in_bus.hash_kind  <= r.kind;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note_request(r);
  endtask

  // random gap before the next request, with gap-free stretches
  task automatic pace_sender();
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering until every owed result has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // main sequence
  initial begin
    request_t opening[$];
    board      = new;
    send_burst = 1'b0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_SAVE;
    in_bus.name_head   = '0;
    in_bus.name_tail   = '0;
    in_bus.hash_value  = '0;
    in_bus.hash_kind   = KIND_TEN;

    // directed cases
    opening.push_back(lookup_req(22'h0, KIND_TEN));
    opening.push_back(save_req({64'h0, 24'hABCDEF}, 22'h5));
    opening.push_back(save_req(pack_name("<W9XYZ>"), 22'h6));
    opening.push_back(save_req({64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF}, 22'h3F_FFFF));
    opening.push_back(save_req(pack_name("N0CALL"), 22'h3F_FFFF));
    opening.push_back(save_req({64'h4142_0043_4445_4647, 24'h58_595A}, 22'h0));
    opening.push_back(save_req({64'h4142_4344_4546_4700, 24'hFF_FFFF}, 22'h000ABC));
    opening.push_back(save_req(pack_name("VK2ABC/PORT"), {10'd89, 12'h001}));
    opening.push_back(save_req(pack_name("DL1XYZ"), {10'd89, 12'h002}));
    opening.push_back(save_req({64'h0100_0000_0000_0000, 24'h0}, 22'h15_5555));
    opening.push_back(save_req(pack_name("3B8ZZ"), 22'h2A_AAAA));
    opening.push_back(lookup_req(22'h3FF, KIND_TEN));
    opening.push_back(lookup_req(22'hFFF, KIND_TWELVE));
    opening.push_back(lookup_req(22'h3F_FFFF, KIND_FULL));
    opening.push_back(lookup_req(22'h3F_FFFF, KIND_SPARE));
    opening.push_back(lookup_req(22'h400, KIND_TEN));
    opening.push_back(lookup_req(22'h0, KIND_TEN));
    opening.push_back(lookup_req(22'h000ABC, KIND_FULL));
    opening.push_back(lookup_req(22'd356, KIND_TWELVE));
    opening.push_back(lookup_req(22'h12_3456, KIND_FULL));
    opening.push_back(lookup_req(22'h2A_AAAA >> TWELVE_SH, KIND_TWELVE));
    opening.push_back(save_req(pack_name("G4ABC"), 22'h000ABC));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) begin
      pace_sender();
      send_request(opening[i]);
    end
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 300 || k == 600) drain_results();
      pace_sender();
      send_request(make_request(k));
    end
    in_bus.valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random stalls per result, one long hold to back up the block
  initial begin
    int     stall_left;
    int     taken;
    bit     rx_burst;
    reply_t got;
    stall_left    = 0;
    taken         = 0;
    rx_burst      = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.found  = out_bus.found;
        got.head   = out_bus.found_head;
        got.tail   = out_bus.found_tail;
        got.status = out_bus.save_status;
        got.count  = out_bus.entry_count;
        board.check_reply(got);
        taken++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : $urandom_range(0, 15);
        if (taken == HOLD_AT) stall_left = HOLD_CYCLES;
      end else if (out_bus.valid && stall_left != 0) begin
        stall_left--;
      end
      out_bus.ready <= rst_n && stall_left == 0;
    end
  end

  // watchdog on cycles with no request or result taken
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/chc_pkg.sv
rtl/chc_if.sv
rtl/chc_store.sv
rtl/chc_bucket_mod.sv
rtl/callsign_hash_cache.sv
sim/tb_top.sv
